// ===== rtl/sgr_attribute_decoder_macros.svh =====
// Assertion macros used by the SGR decoder checker.
`ifndef SGR_ATTRIBUTE_DECODER_MACROS_SVH
`define SGR_ATTRIBUTE_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SGR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgr assertion failed");

// Next-cycle implication, disabled during reset.
`define SGR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sgr assertion failed");

`endif

// ===== rtl/sgr_pkg.sv =====
// Types, codes and constants of the SGR attribute decoder.
package sgr_pkg;

  localparam int VALUE_W = 16;
  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 8;

  localparam logic [VALUE_W-1:0] CHAN_MAX = 16'd255;

  // Plain SGR codes
  localparam logic [VALUE_W-1:0] SGR_RESET      = 16'd0;
  localparam logic [VALUE_W-1:0] SGR_BOLD       = 16'd1;
  localparam logic [VALUE_W-1:0] SGR_FAINT      = 16'd2;
  localparam logic [VALUE_W-1:0] SGR_ITALIC     = 16'd3;
  localparam logic [VALUE_W-1:0] SGR_UNDER      = 16'd4;
  localparam logic [VALUE_W-1:0] SGR_REVERSE    = 16'd7;
  localparam logic [VALUE_W-1:0] SGR_CROSSED    = 16'd9;
  localparam logic [VALUE_W-1:0] SGR_NO_BFI     = 16'd10;
  localparam logic [VALUE_W-1:0] SGR_NO_BF      = 16'd22;
  localparam logic [VALUE_W-1:0] SGR_NO_ITALIC  = 16'd23;
  localparam logic [VALUE_W-1:0] SGR_NO_UNDER   = 16'd24;
  localparam logic [VALUE_W-1:0] SGR_NO_REVERSE = 16'd27;
  localparam logic [VALUE_W-1:0] SGR_NO_CROSSED = 16'd29;
  localparam logic [VALUE_W-1:0] SGR_FG_LO      = 16'd30;
  localparam logic [VALUE_W-1:0] SGR_FG_HI      = 16'd37;
  localparam logic [VALUE_W-1:0] SGR_FG_EXT     = 16'd38;
  localparam logic [VALUE_W-1:0] SGR_FG_DEF     = 16'd39;
  localparam logic [VALUE_W-1:0] SGR_BG_LO      = 16'd40;
  localparam logic [VALUE_W-1:0] SGR_BG_HI      = 16'd47;
  localparam logic [VALUE_W-1:0] SGR_BG_EXT     = 16'd48;
  localparam logic [VALUE_W-1:0] SGR_BG_DEF     = 16'd49;
  localparam logic [VALUE_W-1:0] SGR_FG_BR_LO   = 16'd90;
  localparam logic [VALUE_W-1:0] SGR_FG_BR_HI   = 16'd97;
  localparam logic [VALUE_W-1:0] SGR_BG_BR_LO   = 16'd100;
  localparam logic [VALUE_W-1:0] SGR_BG_BR_HI   = 16'd107;

  // Extended colour modes
  localparam logic [VALUE_W-1:0] EXT_MODE_INDEX = 16'd5;
  localparam logic [VALUE_W-1:0] EXT_MODE_RGB   = 16'd2;

  localparam logic [CHAN_W-1:0] IDX_BRIGHT = 8'd8;

  // Flag masks
  localparam logic [7:0] FL_BOLD    = 8'h01;
  localparam logic [7:0] FL_FAINT   = 8'h02;
  localparam logic [7:0] FL_ITALIC  = 8'h04;
  localparam logic [7:0] FL_UNDER   = 8'h08;
  localparam logic [7:0] FL_REVERSE = 8'h10;
  localparam logic [7:0] FL_CROSSED = 8'h20;
  localparam logic [7:0] FL_DEF_FG  = 8'h40;
  localparam logic [7:0] FL_DEF_BG  = 8'h80;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_MODE  = 3'd1,
    PH_INDEX = 3'd2,
    PH_RED   = 3'd3,
    PH_GREEN = 3'd4,
    PH_BLUE  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_IDX  = 2'd1,
    KIND_RGB  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PENDING = 2'd1,
    ST_ERROR   = 2'd2
  } status_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               first;
    logic               last;
    logic               no_params;
  } sgr_item_t;

  typedef struct packed {
    logic [7:0]         attr;
    kind_t              fore_kind;
    logic [COLOR_W-1:0] fore_value;
    kind_t              back_kind;
    logic [COLOR_W-1:0] back_value;
    phase_t             phase;
    logic               ext_is_fore;
    logic [CHAN_W-1:0]  red_hold;
    logic [CHAN_W-1:0]  green_hold;
    logic               seq_failed;
  } sgr_state_t;

  localparam sgr_state_t STATE_RESET = '{
    attr:        FL_DEF_FG | FL_DEF_BG,
    fore_kind:   KIND_NONE,
    fore_value:  '0,
    back_kind:   KIND_NONE,
    back_value:  '0,
    phase:       PH_IDLE,
    ext_is_fore: 1'b0,
    red_hold:    '0,
    green_hold:  '0,
    seq_failed:  1'b0
  };

  // Register-side control for the input stage
  typedef struct packed {
    logic valid;
    logic ready;
  } sgr_in_ctl_t;

endpackage

// ===== rtl/sgr_in_reg.sv =====
// Input register stage of the SGR decoder.
module sgr_in_reg
  import sgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  sgr_item_t   in_item,
  input  logic        take,
  output sgr_in_ctl_t ctl,
  output sgr_item_t   item
);

  logic valid;

  // Refill whenever empty or being drained this cycle.
  assign ctl.ready = !valid || take;
  assign ctl.valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ===== rtl/sgr_step.sv =====
// Combinational decode of one SGR parameter against the current state.
module sgr_step
  import sgr_pkg::*;
(
  input  sgr_state_t cur,
  input  sgr_item_t  item,
  output sgr_state_t nxt,
  output status_t    status,
  output logic       done
);

  function automatic sgr_state_t set_colour(sgr_state_t s, logic fore, kind_t k,
                                            logic [COLOR_W-1:0] v);
    sgr_state_t r;
    r = s;
    if (fore) begin
      r.attr       = s.attr & ~FL_DEF_FG;
      r.fore_kind  = k;
      r.fore_value = v;
    end else begin
      r.attr       = s.attr & ~FL_DEF_BG;
      r.back_kind  = k;
      r.back_value = v;
    end
    return r;
  endfunction

  function automatic logic [CHAN_W-1:0] clamp8(logic [VALUE_W-1:0] v);
    return (v > CHAN_MAX) ? CHAN_W'(CHAN_MAX) : v[CHAN_W-1:0];
  endfunction

  logic [CHAN_W-1:0] lo8;
  assign lo8 = item.value[CHAN_W-1:0];

  always_comb begin
    sgr_state_t s;
    logic       ok;
    s      = cur;
    ok     = 1'b1;
    status = ST_OK;
    done   = item.last;

    if (item.no_params) begin
      s.attr       = STATE_RESET.attr;
      s.fore_kind  = KIND_NONE;
      s.fore_value = '0;
      s.back_kind  = KIND_NONE;
      s.back_value = '0;
      s.phase      = PH_IDLE;
      s.seq_failed = 1'b0;
      done         = 1'b1;
    end else begin
      if (item.first) begin
        s.phase      = PH_IDLE;
        s.seq_failed = 1'b0;
      end
      if (s.seq_failed) begin
        status = ST_ERROR;
      end else begin
        if (s.phase == PH_IDLE) begin
          unique case (item.value) inside
            [SGR_FG_LO:SGR_FG_HI]:
              s = set_colour(s, 1'b1, KIND_IDX, COLOR_W'(lo8 - CHAN_W'(SGR_FG_LO)));
            [SGR_BG_LO:SGR_BG_HI]:
              s = set_colour(s, 1'b0, KIND_IDX, COLOR_W'(lo8 - CHAN_W'(SGR_BG_LO)));
            [SGR_FG_BR_LO:SGR_FG_BR_HI]:
              s = set_colour(s, 1'b1, KIND_IDX,
                             COLOR_W'(lo8 - CHAN_W'(SGR_FG_BR_LO) + IDX_BRIGHT));
            [SGR_BG_BR_LO:SGR_BG_BR_HI]:
              s = set_colour(s, 1'b0, KIND_IDX,
                             COLOR_W'(lo8 - CHAN_W'(SGR_BG_BR_LO) + IDX_BRIGHT));
            SGR_RESET: begin
              s.attr       = STATE_RESET.attr;
              s.fore_kind  = KIND_NONE;
              s.fore_value = '0;
              s.back_kind  = KIND_NONE;
              s.back_value = '0;
            end
            SGR_BOLD:       s.attr = s.attr | FL_BOLD;
            SGR_FAINT:      s.attr = s.attr | FL_FAINT;
            SGR_ITALIC:     s.attr = s.attr | FL_ITALIC;
            SGR_UNDER:      s.attr = s.attr | FL_UNDER;
            SGR_REVERSE:    s.attr = s.attr | FL_REVERSE;
            SGR_CROSSED:    s.attr = s.attr | FL_CROSSED;
            SGR_NO_BFI:     s.attr = s.attr & ~(FL_BOLD | FL_FAINT | FL_ITALIC);
            SGR_NO_BF:      s.attr = s.attr & ~(FL_BOLD | FL_FAINT);
            SGR_NO_ITALIC:  s.attr = s.attr & ~FL_ITALIC;
            SGR_NO_UNDER:   s.attr = s.attr & ~FL_UNDER;
            SGR_NO_REVERSE: s.attr = s.attr & ~FL_REVERSE;
            SGR_NO_CROSSED: s.attr = s.attr & ~FL_CROSSED;
            SGR_FG_DEF:     s.attr = s.attr | FL_DEF_FG;
            SGR_BG_DEF:     s.attr = s.attr | FL_DEF_BG;
            SGR_FG_EXT: begin
              s.ext_is_fore = 1'b1;
              s.phase       = PH_MODE;
            end
            SGR_BG_EXT: begin
              s.ext_is_fore = 1'b0;
              s.phase       = PH_MODE;
            end
            default: ok = 1'b0;
          endcase
        end else begin
          unique case (s.phase)
            PH_MODE: begin
              if (item.value == EXT_MODE_INDEX) begin
                s.phase = PH_INDEX;
              end else if (item.value == EXT_MODE_RGB) begin
                s.phase = PH_RED;
              end else begin
                s.phase = PH_IDLE;
                ok      = 1'b0;
              end
            end
            PH_INDEX: begin
              s.phase = PH_IDLE;
              if (item.value > CHAN_MAX) begin
                ok = 1'b0;
              end else begin
                s = set_colour(s, s.ext_is_fore, KIND_IDX, COLOR_W'(lo8));
              end
            end
            PH_RED: begin
              s.red_hold = clamp8(item.value);
              s.phase    = PH_GREEN;
            end
            PH_GREEN: begin
              s.green_hold = clamp8(item.value);
              s.phase      = PH_BLUE;
            end
            default: begin
              s.phase = PH_IDLE;
              s = set_colour(s, s.ext_is_fore, KIND_RGB,
                             {s.red_hold, s.green_hold, clamp8(item.value)});
            end
          endcase
        end

        if (!ok) begin
          s.seq_failed = 1'b1;
          s.phase      = PH_IDLE;
          status       = ST_ERROR;
        end else if (s.phase != PH_IDLE) begin
          status = item.last ? ST_ERROR : ST_PENDING;
        end
      end
      if (item.last) begin
        s.phase      = PH_IDLE;
        s.seq_failed = 1'b0;
      end
    end
    nxt = s;
  end

endmodule

// ===== rtl/sgr_attribute_decoder.sv =====
// Top level of the SGR attribute decoder: input stage, decode, result register.
//
// Decodes the numeric parameters of ECMA-48 Select Graphic Rendition
// sequences, one parameter per request, and after each one returns the full
// rendition state (flags, foreground and background colour) plus a status.
// Throughput is one request per clock while the output is not stalled; an
// accepted request passes through the input register, then the decode
// writes the attribute state and the result register together. The decode
// reads the attribute state and computes its next value combinationally,
// and that register loop sets the rate. The output
// register and the input register advance together, so a new request is
// taken while a finished result still waits as long as the result is taken
// in the same cycle; with the output stalled, one more request is parked in
// the input register before s_axis_tready drops. Codes: 0 reset, 1/2/3/4/7/9
// set bold/faint/italic/underline/reverse/crossed, 10/22/23/24/27/29 clear
// them, 30-37/90-97 and 40-47/100-107 pick indexed colours, 39/49 restore
// defaults, and 38/48 start the 5;index or 2;r;g;b extended forms (channels
// clamp to 255). An unknown code, an index above 255 or an extended colour
// cut off by tlast gives status 2 and mutes the rest of the sequence;
// earlier changes stay. A request with no_params set resets everything.
module sgr_attribute_decoder
  import sgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] value
  input  logic [1:0]  s_axis_tuser,   // [0] first, [1] no_params
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [7:0] attr_flags, [9:8] fg_kind,
                                      // [33:10] fg_color, [35:34] bg_kind,
                                      // [59:36] bg_color, [63:60] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast    // done_res
);

  sgr_item_t   in_item;
  sgr_item_t   item;
  sgr_in_ctl_t in_ctl;
  sgr_state_t  st;
  sgr_state_t  st_next;
  status_t     step_status;
  logic        step_done;
  logic        res_load;

  // Result register payload
  logic                res_valid;
  logic [7:0]          res_attr;
  kind_t               res_fg_kind;
  logic [COLOR_W-1:0]  res_fg_color;
  kind_t               res_bg_kind;
  logic [COLOR_W-1:0]  res_bg_color;
  status_t             res_status;
  logic                res_done;

  assign in_item.value     = s_axis_tdata;
  assign in_item.first     = s_axis_tuser[0];
  assign in_item.no_params = s_axis_tuser[1];
  assign in_item.last      = s_axis_tlast;

  // Decode fires when an item sits in the input stage and the output slot is free.
  assign res_load = in_ctl.valid && (!res_valid || m_axis_tready);

  sgr_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_item  (in_item),
    .take     (res_load),
    .ctl      (in_ctl),
    .item     (item)
  );

  assign s_axis_tready = in_ctl.ready;

  sgr_step u_step (
    .cur    (st),
    .item   (item),
    .nxt    (st_next),
    .status (step_status),
    .done   (step_done)
  );

  // Rendition state, updated once per decoded request
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (res_load) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_attr     <= st_next.attr;
      res_fg_kind  <= st_next.fore_kind;
      res_fg_color <= st_next.fore_value;
      res_bg_kind  <= st_next.back_kind;
      res_bg_color <= st_next.back_value;
      res_status   <= step_status;
      res_done     <= step_done;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {4'd0, res_bg_color, res_bg_kind, res_fg_color, res_fg_kind,
                          res_attr};
  assign m_axis_tuser  = res_status;
  assign m_axis_tlast  = res_done;

endmodule

// ===== rtl/sgr_checker.sv =====
// Port-level checks of the SGR decoder, bound to the top level.
`include "sgr_attribute_decoder_macros.svh"

module sgr_checker
  import sgr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // Stalled result holds its value.
  `SGR_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // A pending extended colour is never reported on the closing request.
  `SGR_ASSERT_NOW(a_pend_not_last, clk, rst, m_axis_tvalid && (m_axis_tuser == ST_PENDING), !m_axis_tlast)

  // A foreground with no colour kind carries a zero value.
  `SGR_ASSERT_NOW(a_fg_none_zero, clk, rst, m_axis_tvalid && (m_axis_tdata[9:8] == KIND_NONE), m_axis_tdata[33:10] == 24'd0)

  // With the output empty, the input side is always open.
  `SGR_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_axis_tvalid, s_axis_tready)

endmodule

bind sgr_attribute_decoder sgr_checker u_sgr_checker (.*);
